// ===== src/wdq_pkg.sv =====
// Shared types and constants for the wakeup deadline queue.
// No dependencies; used by wdq_cell and wakeup_deadline_queue_core.
`default_nettype none

package wdq_pkg;

    localparam int KEY_W     = 32;
    localparam int ENTRIES_W = 5;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_PURGE,
        S_EMIT
    } t_state;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_REARM = 1'b1;

endpackage

`default_nettype wire

// ===== src/wdq_cell.sv =====
// One cell of the sorted deadline chain: holds one slot, values ascending away from cell 0.
// Depends on wdq_pkg.
`default_nettype none

module wdq_cell (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire wdq_pkg::t_cell_ctl       i_ctl,
    input  wire  [wdq_pkg::KEY_W-1:0]     i_key,
    input  wire wdq_pkg::t_slot           i_prev,
    input  wire                           i_prev_moves,
    input  wire wdq_pkg::t_slot           i_next,
    output wdq_pkg::t_slot                o_slot,
    output logic                          o_moves
);

    wdq_pkg::t_slot r_slot;
    wdq_pkg::t_slot n_slot;

    // own entry gets pushed toward the tail by the incoming key
    assign o_moves = r_slot.valid && (i_key < r_slot.value);
    assign o_slot  = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.pop) begin
            n_slot = i_next;
        end else if (i_ctl.ins) begin
            if (o_moves || !r_slot.valid) begin
                if (i_prev_moves) begin
                    n_slot = i_prev;
                end else if (o_moves || i_prev.valid) begin
                    n_slot.valid = 1'b1;
                    n_slot.value = i_key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.value <= n_slot.value;
    end

endmodule

`default_nettype wire

// ===== src/wakeup_deadline_queue_core.sv =====
// Wakeup deadline queue: top level with command sequencer and cell chain.
// Depends on wdq_pkg and wdq_cell.
//
// Usage: one transaction on the slave stream carries a command in tuser
// (0 = add now+delay, 1 = purge expired and rearm) and now_ms/delay_ms in
// tdata. Each transaction yields exactly one result transaction on the master
// stream with timer_armed, reload_ms, entries_held and dropped_full.
// Deadlines sit sorted in a chain of cells, earliest in cell 0; an add inserts
// in the S_ADD state, a rearm shifts the chain by one cell per expired deadline.
// A transaction passes from idle through S_ADD, or through S_PURGE, which
// removes the k expired deadlines (k <= QUEUE_DEPTH) one shift per cycle,
// to S_EMIT. The slave side accepts only while the sequencer is idle.
// A finished result sits in the output register; a new transaction may be
// accepted while it waits, and the next result holds until the receiver takes
// the previous one.
// Reset (synchronous, active low) empties the chain and drops any pending result.
`default_nettype none

module wakeup_deadline_queue_core #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int RELOAD_WIDTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [63:0]                       i_s_axis_tdata,  // now_ms[31:0], delay_ms[62:32]
    input  wire                               i_s_axis_tuser,  // command
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // timer_armed, reload_ms, entries_held, dropped_full (low to high)
    output logic [((RELOAD_WIDTH+14)/8)*8-1:0] o_m_axis_tdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int KW    = wdq_pkg::KEY_W;
    localparam int RES_W = RELOAD_WIDTH + wdq_pkg::ENTRIES_W + 2;
    localparam int OUT_W = ((RELOAD_WIDTH + 14) / 8) * 8;
    localparam logic [KW-1:0] RELOAD_MAX = KW'((64'd1 << RELOAD_WIDTH) - 64'd1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    wdq_pkg::t_state r_state, n_state;
    logic [KW-1:0]            r_now;
    logic [KW-1:0]            r_key;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [RES_W-1:0]         r_res, n_res;
    logic                     r_out_valid, n_out_valid;
    logic [RES_W-1:0]         r_out_data, n_out_data;

    wdq_pkg::t_cell_ctl       w_ctl;
    wdq_pkg::t_slot           w_slot  [QUEUE_DEPTH];
    logic                     w_moves [QUEUE_DEPTH];
    wdq_pkg::t_slot           w_prev  [QUEUE_DEPTH];
    logic                     w_prev_moves [QUEUE_DEPTH];
    wdq_pkg::t_slot           w_next  [QUEUE_DEPTH];

    logic [KW:0]              w_sum;
    logic [KW-1:0]            w_diff;
    logic [KW-1:0]            w_sat;
    logic                     w_accept;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == wdq_pkg::S_IDLE);
    assign w_sum = {1'b0, i_s_axis_tdata[31:0]} + {2'b00, i_s_axis_tdata[62:32]};
    assign w_diff = w_slot[0].value - r_now;
    assign w_sat  = (w_diff > RELOAD_MAX) ? RELOAD_MAX : w_diff;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                // head sees an always-occupied, never-moving neighbor
                assign w_prev[g].valid   = 1'b1;
                assign w_prev[g].value   = '0;
                assign w_prev_moves[g]   = 1'b0;
            end else begin : g_body
                assign w_prev[g]         = w_slot[g-1];
                assign w_prev_moves[g]   = w_moves[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next[g].valid   = 1'b0;
                assign w_next[g].value   = '0;
            end else begin : g_inner
                assign w_next[g]         = w_slot[g+1];
            end
            wdq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key        (r_key),
                .i_prev       (w_prev[g]),
                .i_prev_moves (w_prev_moves[g]),
                .i_next       (w_next[g]),
                .o_slot       (w_slot[g]),
                .o_moves      (w_moves[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_ctl.ins   = 1'b0;
        w_ctl.pop   = 1'b0;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            wdq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_s_axis_tuser == wdq_pkg::CMD_REARM) ? wdq_pkg::S_PURGE
                                                                     : wdq_pkg::S_ADD;
                end
            end
            wdq_pkg::S_ADD: begin
                if (r_count == FULL) begin
                    n_res = {1'b1, wdq_pkg::ENTRIES_W'(r_count), RELOAD_WIDTH'(0), 1'b0};
                end else begin
                    w_ctl.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                    n_res = {1'b0, wdq_pkg::ENTRIES_W'(n_count), RELOAD_WIDTH'(0), 1'b0};
                end
                n_state = wdq_pkg::S_EMIT;
            end
            wdq_pkg::S_PURGE: begin
                if (w_slot[0].valid && (w_slot[0].value <= r_now)) begin
                    w_ctl.pop = 1'b1;
                    n_count   = r_count - 1'b1;
                end else begin
                    n_res = {1'b0, wdq_pkg::ENTRIES_W'(r_count),
                             w_slot[0].valid ? w_sat[RELOAD_WIDTH-1:0] : RELOAD_WIDTH'(0),
                             w_slot[0].valid};
                    n_state = wdq_pkg::S_EMIT;
                end
            end
            wdq_pkg::S_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = wdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wdq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_res      <= n_res;
        r_out_data <= n_out_data;
        if (w_accept) begin
            r_now <= i_s_axis_tdata[31:0];
            r_key <= w_sum[KW] ? {KW{1'b1}} : w_sum[KW-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);

endmodule

`default_nettype wire
